/* hdl/str2i_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// str2i_pkg
// Shared types and constants of the streaming string to 64-bit integer parser.
// ----------------------------------------------------------------------------
package str2i_pkg;

   localparam int CHAR_W      = 8;
   localparam int VALUE_W     = 64;
   localparam int STATUS_W    = 2;
   localparam int CONSUMED_W  = 16;
   localparam int BASE_W      = 6;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [VALUE_W-1:0] SIGNED_CEILING   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] SIGNED_FLOOR     = 64'h8000_0000_0000_0000;
   localparam logic [VALUE_W-1:0] UNSIGNED_CEILING = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
   localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
   localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
   localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_BASE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNED_MODE = 4'd1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      PH_SPACE  = 3'd0,
      PH_SIGNED = 3'd1,
      PH_ZFIRST = 3'd2,
      PH_XSEEN  = 3'd3,
      PH_DIGITS = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   typedef struct packed {
      phase_type            phase;
      logic                 negative;
      logic [VALUE_W-1:0]   accumulator;
      logic [BASE_W-1:0]    active_base;
      logic                 any_digits;
      logic                 overflowed;
   } parse_state_type;

   localparam parse_state_type PARSE_RESET = '{
      phase:       PH_SPACE,
      negative:    1'b0,
      accumulator: '0,
      active_base: '0,
      any_digits:  1'b0,
      overflowed:  1'b0
   };

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      status_type         status;
      logic               mark_end;
   } step_result_type;

endpackage : str2i_pkg
`default_nettype wire

/* hdl/str2i_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// str2i_req_if
// Request channel: one character per request, with a last flag.
// ----------------------------------------------------------------------------
interface str2i_req_if
   import str2i_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] character;
   logic              is_last;

   modport source (output valid, output character, output is_last, input ready);
   modport sink   (input valid, input character, input is_last, output ready);
endinterface : str2i_req_if
`default_nettype wire

/* hdl/str2i_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// str2i_rsp_if
// Result channel: parsed value, status and consumed length.
// ----------------------------------------------------------------------------
interface str2i_rsp_if
   import str2i_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [VALUE_W-1:0]    value;
   logic [STATUS_W-1:0]   status;
   logic [CONSUMED_W-1:0] consumed;

   modport source (output valid, output value, output status, output consumed,
                   input ready);
   modport sink   (input valid, input value, input status, input consumed,
                   output ready);
endinterface : str2i_rsp_if
`default_nettype wire

/* hdl/str2i_csr_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// str2i_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface str2i_csr_if
   import str2i_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface : str2i_csr_if
`default_nettype wire

/* hdl/string_to_int64_parser_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// string_to_int64_parser_top
// Streaming string to 64-bit integer parser (strtoll / strtoull style).
//
// Each request carries one character and a last flag. Every string yields one
// response on its last character: value, status (ok, invalid, overflow) and
// the number of characters up to and including the number's last digit.
// Requests pass an input register, then the per-character parse step (one
// multiply-add by the radix with a range check) loads the parse state and,
// on the last character, the response register, which drives the response
// valid. One character is accepted every cycle unless a last character waits
// behind a stalled response.
// A stalled response only holds the input stage when a last character waits
// behind it; other characters keep flowing.
// The csr channel writes number_base (index 0) and signed_mode (index 1); it
// is always ready and should be written only while no string is in flight.
// Reset clears the parse state, both channel valids, number_base to 0 and
// signed_mode to 1.
// ----------------------------------------------------------------------------
module string_to_int64_parser_top
   import str2i_pkg::*;
#(
   parameter int MAX_LENGTH_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   str2i_req_if.sink   req_ch,
   str2i_rsp_if.source rsp_ch,
   str2i_csr_if.sink   csr_ch
);
   localparam int POS_W = MAX_LENGTH_BITS;
   localparam int END_W = MAX_LENGTH_BITS + 1;

   logic                  in_valid_ff;
   logic [CHAR_W-1:0]     in_char_ff;
   logic                  in_last_ff;
   logic                  advance;

   logic [BASE_W-1:0]     number_base_ff;
   logic                  signed_mode_ff;

   parse_state_type       state_ff;
   parse_state_type       state_in;
   step_result_type       step_res;
   logic [POS_W-1:0]      position_ff;
   logic [END_W-1:0]      number_end_ff;
   logic [END_W-1:0]      number_end_in;
   logic [CONSUMED_W-1:0] consumed;

   logic                  rsp_valid_ff;
   logic [VALUE_W-1:0]    rsp_value_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [CONSUMED_W-1:0] rsp_consumed_ff;

   assign advance      = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.ready && req_ch.valid) begin
         in_char_ff <= req_ch.character;
         in_last_ff <= req_ch.is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= BASE_AUTO;
         signed_mode_ff <= 1'b1;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == CSR_NUMBER_BASE) begin
            number_base_ff <= csr_ch.data[BASE_W-1:0];
         end else if (csr_ch.index == CSR_SIGNED_MODE) begin
            signed_mode_ff <= csr_ch.data[0];
         end
      end
   end

   str2i_step u_step (
      .state       (state_ff),
      .character   (in_char_ff),
      .is_last     (in_last_ff),
      .number_base (number_base_ff),
      .signed_mode (signed_mode_ff),
      .state_next  (state_in),
      .result      (step_res)
   );

   assign number_end_in = step_res.mark_end ?
                          ({1'b0, position_ff} + END_W'(1)) : number_end_ff;

   generate
      if (END_W >= CONSUMED_W) begin : g_end_trunc
         assign consumed = number_end_in[CONSUMED_W-1:0];
      end else begin : g_end_ext
         assign consumed = {{(CONSUMED_W - END_W){1'b0}}, number_end_in};
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= PARSE_RESET;
         position_ff   <= '0;
         number_end_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         if (in_last_ff) begin
            position_ff   <= '0;
            number_end_ff <= '0;
         end else begin
            number_end_ff <= number_end_in;
            if (position_ff != {POS_W{1'b1}}) begin
               position_ff <= position_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && in_last_ff) begin
         rsp_value_ff    <= step_res.value;
         rsp_status_ff   <= step_res.status;
         rsp_consumed_ff <= consumed;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.value    = rsp_value_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.consumed = rsp_consumed_ff;
endmodule : string_to_int64_parser_top
`default_nettype wire

/* hdl/str2i_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// str2i_mac
// Multiply-add of one digit into the accumulator with a widened range check.
// ----------------------------------------------------------------------------
module str2i_mac
   import str2i_pkg::*;
(
   input  wire logic [VALUE_W-1:0] accumulator,
   input  wire logic [BASE_W-1:0]  base,
   input  wire logic [BASE_W-1:0]  digit,
   input  wire logic [VALUE_W-1:0] limit,
   output logic      [VALUE_W-1:0] sum,
   output logic                    over
);
   localparam int PROD_W = VALUE_W + BASE_W;

   logic [PROD_W-1:0] product;
   logic [PROD_W:0]   wide;

   assign product = {{BASE_W{1'b0}}, accumulator} * {{VALUE_W{1'b0}}, base};
   assign wide    = {1'b0, product} + {{(PROD_W + 1 - BASE_W){1'b0}}, digit};
   assign over    = wide > {{(PROD_W + 1 - VALUE_W){1'b0}}, limit};
   assign sum     = wide[VALUE_W-1:0];
endmodule : str2i_mac
`default_nettype wire

/* hdl/str2i_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// str2i_step
// Next parse state and result for one character.
// ----------------------------------------------------------------------------
module str2i_step
   import str2i_pkg::*;
(
   input  wire parse_state_type     state,
   input  wire logic [CHAR_W-1:0]   character,
   input  wire logic                is_last,
   input  wire logic [BASE_W-1:0]   number_base,
   input  wire logic                signed_mode,
   output parse_state_type          state_next,
   output step_result_type          result
);
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
   localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
   localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

   parse_state_type    upd;
   logic               is_digit;
   logic [BASE_W-1:0]  digit;
   logic               is_space;
   logic [BASE_W-1:0]  first_base;
   logic               bad_base;
   logic [BASE_W-1:0]  mac_base;
   logic [VALUE_W-1:0] mac_acc;
   logic [VALUE_W-1:0] limit;
   logic [VALUE_W-1:0] mac_sum;
   logic               mac_over;
   logic               do_acc;
   logic               mark_end;

   always_comb begin
      is_digit = 1'b1;
      digit    = '0;
      if (character >= CH_ZERO && character <= CH_NINE) begin
         digit = BASE_W'(character - CH_ZERO);
      end else if (character >= CH_UA && character <= CH_UZ) begin
         digit = BASE_W'(character - CH_UA) + BASE_DEC;
      end else if (character >= CH_LA && character <= CH_LZ) begin
         digit = BASE_W'(character - CH_LA) + BASE_DEC;
      end else begin
         is_digit = 1'b0;
      end
   end

   assign is_space   = (character == CH_SPACE) || (character >= CH_TAB && character <= CH_CR);
   assign bad_base   = (number_base == BASE_ONE) || (number_base > BASE_MAX);
   assign first_base = (number_base == BASE_AUTO) ?
                       ((character == CH_ZERO) ? BASE_OCT : BASE_DEC) : number_base;
   assign limit      = !signed_mode ? UNSIGNED_CEILING :
                       (state.negative ? SIGNED_FLOOR : SIGNED_CEILING);

   always_comb begin
      upd      = state;
      do_acc   = 1'b0;
      mac_base = state.active_base;
      mac_acc  = state.accumulator;
      case (state.phase)
         PH_SPACE, PH_SIGNED: begin
            if (state.phase == PH_SPACE && is_space) begin
               upd = state;
            end else if (state.phase == PH_SPACE && character == CH_MINUS) begin
               upd.negative = 1'b1;
               upd.phase    = PH_SIGNED;
            end else if (state.phase == PH_SPACE && character == CH_PLUS) begin
               upd.phase = PH_SIGNED;
            end else if (bad_base) begin
               upd.phase = PH_DONE;
            end else begin
               upd.active_base = first_base;
               mac_base        = first_base;
               if (!is_digit || digit >= first_base) begin
                  upd.phase = PH_DONE;
               end else begin
                  do_acc = 1'b1;
                  upd.phase = (character == CH_ZERO &&
                               (number_base == BASE_AUTO || number_base == BASE_HEX)) ?
                              PH_ZFIRST : PH_DIGITS;
               end
            end
         end
         PH_ZFIRST: begin
            if (character == CH_LX || character == CH_UX) begin
               upd.phase = PH_XSEEN;
            end else begin
               upd.phase = PH_DIGITS;
               if (is_digit && digit < state.active_base) begin
                  do_acc = 1'b1;
               end else begin
                  upd.phase = PH_DONE;
               end
            end
         end
         PH_XSEEN: begin
            if (is_digit && digit < BASE_HEX) begin
               upd.active_base = BASE_HEX;
               upd.accumulator = '0;
               upd.phase       = PH_DIGITS;
               mac_base        = BASE_HEX;
               mac_acc         = '0;
               do_acc          = 1'b1;
            end else begin
               upd.phase = PH_DONE;
            end
         end
         PH_DIGITS: begin
            if (is_digit && digit < state.active_base) begin
               do_acc = 1'b1;
            end else begin
               upd.phase = PH_DONE;
            end
         end
         default: begin
            upd = state;
         end
      endcase
      mark_end = do_acc;
      if (do_acc) begin
         upd.any_digits = 1'b1;
         if (state.overflowed || mac_over) begin
            upd.overflowed = 1'b1;
         end else begin
            upd.accumulator = mac_sum;
         end
      end
   end

   str2i_mac u_mac (
      .accumulator (mac_acc),
      .base        (mac_base),
      .digit       (digit),
      .limit       (limit),
      .sum         (mac_sum),
      .over        (mac_over)
   );

   always_comb begin
      result.mark_end = mark_end;
      if (!upd.any_digits) begin
         result.value  = '0;
         result.status = STATUS_INVALID;
      end else if (upd.overflowed) begin
         result.value  = !signed_mode ? UNSIGNED_CEILING :
                         (upd.negative ? SIGNED_FLOOR : SIGNED_CEILING);
         result.status = STATUS_OVERFLOW;
      end else begin
         result.value  = upd.negative ? (VALUE_W'(0) - upd.accumulator) : upd.accumulator;
         result.status = STATUS_OK;
      end
      state_next = is_last ? PARSE_RESET : upd;
   end
endmodule : str2i_step
`default_nettype wire
